// File: src/tki_pkg.sv
// Shared constants and types of the tensor invariant unit.
package tki_pkg;

  // Limb width of the partial-product multiplier.
  localparam int LIMB_W = 32;
  // Register stages through one multiplier.
  localparam int MUL_LAT = 5;
  // Width of the result value.
  localparam int VAL_W = 35;

  typedef enum logic [1:0] {
    OP_K1 = 2'd0,
    OP_K2 = 2'd1,
    OP_K3 = 2'd2
  } op_e;

endpackage

// File: src/tensor_k_invariant_unit.sv
// Top level of the tensor invariant unit: trace, deviatoric norm and mode.
//
// Channel  Dir  Transfer on          Payload
// s_axis   in   tvalid & tready      tdata: xx,xy,xz,yy,yz,zz; tuser: opcode
// m_axis   out  tvalid & tready      tdata: measure_value; tuser: zero_norm
//
// One tensor enters per cycle while the pipeline advances. The latency is set by
// the longer of two paths: the norm path (first multiplier layer, the COMP_BITS+3
// stage root, the divide by 3) and the mode path (three multiplier layers, the
// FRAC_BITS+1 stage root).
// The whole pipeline moves on one advance strobe; a two-entry output buffer
// lets transfers continue while a result waits. The pipeline stops only when
// the buffer is full, the downstream is not ready and a result is due.
// Reset clears the valid bits and the buffer count; data registers are not reset.
module tensor_k_invariant_unit #(
  parameter int COMP_BITS = 32,
  parameter int FRAC_BITS = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // comp_xx, comp_xy, comp_xz, comp_yy, comp_yz, comp_zz, zero pad to bytes
  input  logic [((6*COMP_BITS+7)/8)*8-1:0] s_axis_tdata,
  // opcode
  input  logic [1:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // measure_value, zero pad to bytes
  output logic [((tki_pkg::VAL_W+7)/8)*8-1:0] m_axis_tdata,
  // zero_norm
  output logic m_axis_tuser
);

  localparam int W    = COMP_BITS;
  localparam int F    = FRAC_BITS;
  localparam int VW   = tki_pkg::VAL_W;
  localparam int OW   = ((VW + 7) / 8) * 8;
  localparam int LM   = tki_pkg::MUL_LAT;
  localparam int DW   = W + 2;          // scaled deviatoric entries
  localparam int TRW  = W + 2;          // trace
  localparam int SQW  = 2 * DW;         // squares and pair products
  localparam int SW   = 2 * W + 6;      // S, unsigned
  localparam int DETW = 3 * W + 7;      // det(D), signed
  localparam int MW   = 3 * SW;         // S^3
  localparam int NW   = MW + 2 * F;     // 54 det^2 4^F
  localparam int N2   = W + 3;          // bits of sqrt(S)
  localparam logic [63:0] RECIP64 = ((64'd1 << (N2+2)) + 64'd2) / 64'd3;

  // stage where each value is held in a register
  localparam int ST_P    = 2 + LM;
  localparam int ST_Q    = ST_P + LM + 1;
  localparam int ST_R    = ST_Q + LM + 1;
  localparam int ST_E3   = ST_R + F + 1;
  localparam int ST_E2   = ST_P + N2 + LM;
  localparam int ST_LAST = ((ST_E2 > ST_E3) ? ST_E2 : ST_E3) + 1;

  localparam int KW  = (TRW > VW) ? TRW : VW;
  localparam int UW  = (N2 > VW) ? N2 : VW;
  localparam logic signed [KW-1:0] K1_MAX = (KW'(1) << (VW-1)) - KW'(1);
  localparam logic signed [KW-1:0] K1_MIN = -K1_MAX - KW'(1);
  localparam logic [UW-1:0]        K2_MAX = (UW'(1) << (VW-1)) - UW'(1);

  typedef struct packed {
    logic [1:0]            op;
    logic signed [TRW-1:0] tr;
  } side_t;

  typedef struct packed {
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
    logic signed [DW-1:0] c;
    logic signed [DW-1:0] f;
  } abcf_t;

  typedef struct packed {
    logic [VW-1:0] val;
    logic          zero;
  } res_t;

  // handshake and pipeline advance
  logic       adv;
  logic       accept;
  logic       pop;
  logic       push;
  logic       head_ld;
  logic [1:0] cnt_q;
  res_t       ent_q [2];
  res_t       res_d;
  logic       vld_q [ST_LAST];

  assign pop    = m_axis_tvalid && m_axis_tready;
  assign push   = adv && vld_q[ST_LAST-1];
  assign adv    = !(vld_q[ST_LAST-1] && (cnt_q == 2'd2) && !m_axis_tready);
  assign accept = s_axis_tvalid && adv;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ST_LAST; i++) vld_q[i] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= accept;
      for (int i = 1; i < ST_LAST; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // stage 1: scaled deviatoric D = 3 dev, trace
  logic signed [W-1:0]  xx, xy, xz, yy, yz, zz;
  logic signed [DW-1:0] dv_d [6];
  logic signed [DW-1:0] dv_q [6];
  side_t                side_d;

  assign xx = s_axis_tdata[0*W +: W];
  assign xy = s_axis_tdata[1*W +: W];
  assign xz = s_axis_tdata[2*W +: W];
  assign yy = s_axis_tdata[3*W +: W];
  assign yz = s_axis_tdata[4*W +: W];
  assign zz = s_axis_tdata[5*W +: W];

  assign dv_d[0] = (DW'(xx) <<< 1) - DW'(yy) - DW'(zz);
  assign dv_d[1] = (DW'(yy) <<< 1) - DW'(xx) - DW'(zz);
  assign dv_d[2] = (DW'(zz) <<< 1) - DW'(xx) - DW'(yy);
  assign dv_d[3] = (DW'(xy) <<< 1) + DW'(xy);
  assign dv_d[4] = (DW'(xz) <<< 1) + DW'(xz);
  assign dv_d[5] = (DW'(yz) <<< 1) + DW'(yz);
  assign side_d.op = s_axis_tuser;
  assign side_d.tr = TRW'(xx) + TRW'(yy) + TRW'(zz);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q <= dv_d;
    end
  end

  // op and trace ride along to the last stage
  side_t sd_q [ST_LAST];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= side_d;
      for (int i = 1; i < ST_LAST; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  // layer 1: six squares, a*b and d*e
  logic signed [SQW-1:0] sq [6];
  logic signed [SQW-1:0] ab_p, de_p;

  for (genvar k = 0; k < 6; k++) begin : g_sq
    tki_mul #(.AW(DW), .BW(DW)) u_sq (
      .clk_i(clk_i), .en_i(adv), .a_i(dv_q[k]), .b_i(dv_q[k]), .p_o(sq[k])
    );
  end

  tki_mul #(.AW(DW), .BW(DW)) u_ab (
    .clk_i(clk_i), .en_i(adv), .a_i(dv_q[0]), .b_i(dv_q[1]), .p_o(ab_p)
  );
  tki_mul #(.AW(DW), .BW(DW)) u_de (
    .clk_i(clk_i), .en_i(adv), .a_i(dv_q[3]), .b_i(dv_q[4]), .p_o(de_p)
  );

  abcf_t abcf_q [LM+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      abcf_q[0] <= '{a: dv_q[0], b: dv_q[1], c: dv_q[2], f: dv_q[5]};
      for (int i = 1; i <= LM; i++) abcf_q[i] <= abcf_q[i-1];
    end
  end

  // stage P: S = a^2 + b^2 + c^2 + 2(d^2 + e^2 + f^2)
  logic [SW-1:0]         s_d, s_q;
  logic signed [SQW-1:0] dd_q, ee_q, ff_q, ab_q, de_q;
  abcf_t                 abcf_p;
  logic                  zr_q [ST_LAST-ST_P+1];

  assign s_d = SW'(unsigned'(sq[0])) + SW'(unsigned'(sq[1])) + SW'(unsigned'(sq[2]))
             + ((SW'(unsigned'(sq[3])) + SW'(unsigned'(sq[4]))
               + SW'(unsigned'(sq[5]))) << 1);
  assign abcf_p = abcf_q[LM];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_q   <= s_d;
      dd_q  <= sq[3];
      ee_q  <= sq[4];
      ff_q  <= sq[5];
      ab_q  <= ab_p;
      de_q  <= de_p;
      zr_q[0] <= (s_d == '0);
      for (int i = 1; i <= ST_LAST-ST_P; i++) zr_q[i] <= zr_q[i-1];
    end
  end

  // layer 2: the determinant terms and S^2
  logic signed [SQW+DW-1:0] abc_p, def_p, af_p, be_p, cd_p;
  logic signed [2*SW+1:0]   ss_p;

  tki_mul #(.AW(SQW), .BW(DW)) u_abc (
    .clk_i(clk_i), .en_i(adv), .a_i(ab_q), .b_i(abcf_p.c), .p_o(abc_p)
  );
  tki_mul #(.AW(SQW), .BW(DW)) u_def (
    .clk_i(clk_i), .en_i(adv), .a_i(de_q), .b_i(abcf_p.f), .p_o(def_p)
  );
  tki_mul #(.AW(SQW), .BW(DW)) u_af (
    .clk_i(clk_i), .en_i(adv), .a_i(ff_q), .b_i(abcf_p.a), .p_o(af_p)
  );
  tki_mul #(.AW(SQW), .BW(DW)) u_be (
    .clk_i(clk_i), .en_i(adv), .a_i(ee_q), .b_i(abcf_p.b), .p_o(be_p)
  );
  tki_mul #(.AW(SQW), .BW(DW)) u_cd (
    .clk_i(clk_i), .en_i(adv), .a_i(dd_q), .b_i(abcf_p.c), .p_o(cd_p)
  );
  tki_mul #(.AW(SW+1), .BW(SW+1)) u_ss (
    .clk_i(clk_i), .en_i(adv), .a_i({1'b0, s_q}), .b_i({1'b0, s_q}), .p_o(ss_p)
  );

  logic [SW-1:0] sc_q [LM+1];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sc_q[0] <= s_q;
      for (int i = 1; i <= LM; i++) sc_q[i] <= sc_q[i-1];
    end
  end

  // stage Q: det(D) = abc + 2def - a f^2 - b e^2 - c d^2
  logic signed [DETW-1:0] det_q;
  logic [2*SW-1:0]        ss_q;
  logic                   ng_q [ST_LAST-ST_Q];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det_q <= DETW'(abc_p) + (DETW'(def_p) <<< 1)
             - DETW'(af_p) - DETW'(be_p) - DETW'(cd_p);
      ss_q  <= ss_p[2*SW-1:0];
      ng_q[0] <= det_q[DETW-1];
      for (int i = 1; i < ST_LAST-ST_Q; i++) ng_q[i] <= ng_q[i-1];
    end
  end

  // layer 3: det^2 and S^3
  logic signed [2*DETW-1:0]  det2_p;
  logic signed [3*SW+1:0]    s3_p;

  tki_mul #(.AW(DETW), .BW(DETW)) u_det2 (
    .clk_i(clk_i), .en_i(adv), .a_i(det_q), .b_i(det_q), .p_o(det2_p)
  );
  tki_mul #(.AW(2*SW+1), .BW(SW+1)) u_s3 (
    .clk_i(clk_i), .en_i(adv), .a_i({1'b0, ss_q}), .b_i({1'b0, sc_q[LM]}), .p_o(s3_p)
  );

  // stage R: root target 54 det^2 4^F and scale S^3
  logic [NW-1:0] dsq;
  logic [NW-1:0] n_q;
  logic [MW-1:0] m_q;

  assign dsq = NW'(unsigned'(det2_p));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_q <= ((dsq << 5) + (dsq << 4) + (dsq << 2) + (dsq << 1)) << (2*F);
      m_q <= s3_p[MW-1:0];
    end
  end

  // mode magnitude: largest q with q^2 S^3 <= 54 det^2 4^F
  logic [F:0] q3_p;
  logic [F:0] q3_q [ST_LAST-ST_E3];

  tki_root #(.NW(NW), .MW(MW), .QB(F+1)) u_root3 (
    .clk_i(clk_i), .en_i(adv), .tgt_i(n_q), .scl_i(m_q), .root_o(q3_p)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      q3_q[0] <= q3_p;
      for (int i = 1; i < ST_LAST-ST_E3; i++) q3_q[i] <= q3_q[i-1];
    end
  end

  // norm: isqrt(S), then divide by 3 with a reciprocal multiply
  logic [N2-1:0]        r2_p;
  logic signed [2*N2+2:0] k2m_p;
  logic [N2-1:0]        k2_q [ST_LAST-ST_E2];

  tki_root #(.NW(SW), .MW(1), .QB(N2)) u_root2 (
    .clk_i(clk_i), .en_i(adv), .tgt_i(s_q), .scl_i(1'b1), .root_o(r2_p)
  );

  tki_mul #(.AW(N2+1), .BW(N2+2)) u_div3 (
    .clk_i(clk_i), .en_i(adv), .a_i({1'b0, r2_p}), .b_i((N2+2)'(RECIP64)), .p_o(k2m_p)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      k2_q[0] <= k2m_p[N2+2 +: N2];
      for (int i = 1; i < ST_LAST-ST_E2; i++) k2_q[i] <= k2_q[i-1];
    end
  end

  // last stage: saturate and select
  side_t                sd_l;
  logic signed [KW-1:0] k1_x;
  logic [UW-1:0]        k2_x;
  logic [VW-1:0]        k1_v, k2_v, k3_m, k3_v;
  logic                 zr_l;

  assign sd_l = sd_q[ST_LAST-1];
  assign zr_l = zr_q[ST_LAST-ST_P];
  assign k1_x = KW'(sd_l.tr);
  assign k1_v = (k1_x > K1_MAX) ? K1_MAX[VW-1:0] :
                (k1_x < K1_MIN) ? K1_MIN[VW-1:0] : k1_x[VW-1:0];
  assign k2_x = UW'(k2_q[ST_LAST-ST_E2-1]);
  assign k2_v = (k2_x > K2_MAX) ? K2_MAX[VW-1:0] : k2_x[VW-1:0];
  assign k3_m = VW'(q3_q[ST_LAST-ST_E3-1]);
  assign k3_v = zr_l ? '0 : (ng_q[ST_LAST-ST_Q-1] ? -k3_m : k3_m);

  always_comb begin
    res_d.zero = zr_l;
    case (tki_pkg::op_e'(sd_l.op))
      tki_pkg::OP_K1: res_d.val = k1_v;
      tki_pkg::OP_K2: res_d.val = k2_v;
      tki_pkg::OP_K3: res_d.val = k3_v;
      default:        res_d.val = '0;
    endcase
  end

  // two-entry output buffer, head in slot 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // a new result goes straight to the head when the head is free or leaving
  assign head_ld = push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop));

  always_ff @(posedge clk_i) begin
    if (head_ld) begin
      ent_q[0] <= res_d;
    end else if (pop) begin
      ent_q[0] <= ent_q[1];
    end
    if (push && !head_ld) begin
      ent_q[1] <= res_d;
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = OW'(ent_q[0].val);
  assign m_axis_tuser  = ent_q[0].zero;

endmodule

// File: src/tki_mul.sv
// Pipelined signed multiplier built from 32x32 limb products.
module tki_mul #(
  parameter int AW = 34,
  parameter int BW = 34
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int LB = tki_pkg::LIMB_W;
  localparam int NA = (AW + LB - 1) / LB;
  localparam int NB = (BW + LB - 1) / LB;
  localparam int RW = (NB + 1) * LB;
  localparam int PW = (NA + NB) * LB;

  logic [AW-1:0]   a_abs;
  logic [BW-1:0]   b_abs;
  logic [NA*LB-1:0] am_q;
  logic [NB*LB-1:0] bm_q;
  logic [2*LB-1:0] pp_q [NA][NB];
  logic [RW-1:0]   row_d [NA];
  logic [RW-1:0]   row_q [NA];
  logic [PW-1:0]   tot_d;
  logic [PW-1:0]   tot_q;
  logic [AW+BW-1:0] mag;
  logic [3:0]      sg_q;

  assign a_abs = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
  assign b_abs = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);

  // magnitudes, then limb products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am_q  <= (NA*LB)'(a_abs);
      bm_q  <= (NB*LB)'(b_abs);
      sg_q  <= {sg_q[2:0], a_i[AW-1] ^ b_i[BW-1]};
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= am_q[i*LB +: LB] * bm_q[j*LB +: LB];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (j*LB));
      end
    end
  end

  always_comb begin
    tot_d = '0;
    for (int i = 0; i < NA; i++) begin
      tot_d = tot_d + (PW'(row_q[i]) << (i*LB));
    end
  end

  assign mag = tot_q[AW+BW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      row_q <= row_d;
      tot_q <= tot_d;
      p_o   <= sg_q[3] ? -mag : mag;
    end
  end

endmodule

// File: src/tki_root.sv
// Pipelined restoring root: largest q below 2^QB with q*q*scale <= target.
module tki_root #(
  parameter int NW = 70,
  parameter int MW = 1,
  parameter int QB = 35
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] tgt_i,
  input  logic [MW-1:0] scl_i,
  output logic [QB-1:0] root_o
);

  localparam int TW = MW + QB;
  localparam int CW = MW + 2*QB + 1;
  localparam int XW = (NW > CW) ? NW : CW;

  // per stage: remainder target - q^2*scale, q*scale, scale, q
  logic [NW-1:0] r_q [QB];
  logic [TW-1:0] t_q [QB];
  logic [MW-1:0] m_q [QB];
  logic [QB-1:0] q_q [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    localparam int K = QB - 1 - i;
    logic [NW-1:0] r_in;
    logic [TW-1:0] t_in;
    logic [MW-1:0] m_in;
    logic [QB-1:0] q_in;
    logic [XW-1:0] dlt;
    logic [XW-1:0] r_x;
    logic [XW-1:0] r_sub;
    logic          fit;

    if (i == 0) begin : g_first
      assign r_in = tgt_i;
      assign t_in = '0;
      assign m_in = scl_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[i-1];
      assign t_in = t_q[i-1];
      assign m_in = m_q[i-1];
      assign q_in = q_q[i-1];
    end

    // (q + 2^K)^2 * M - q^2 * M = T*2^(K+1) + M*4^K
    assign dlt   = (XW'(t_in) << (K+1)) + (XW'(m_in) << (2*K));
    assign r_x   = XW'(r_in);
    assign fit   = dlt <= r_x;
    assign r_sub = r_x - dlt;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[i] <= fit ? r_sub[NW-1:0] : r_in;
        t_q[i] <= fit ? t_in + (TW'(m_in) << K) : t_in;
        m_q[i] <= m_in;
        q_q[i] <= fit ? (q_in | (QB'(1) << K)) : q_in;
      end
    end
  end

  assign root_o = q_q[QB-1];

endmodule
